[hdl/wfd_pkg.sv]
// ----------------------------------------------------------------------------
// Weighted feature distance package
// Shared widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package wfd_pkg;

	// Feature vector limits.
	localparam int MaxFeatures = 6;
	localparam int NumWeights  = 6;
	localparam int PosW        = 3;

	// Payload and arithmetic widths.
	localparam int ValueW  = 16;
	localparam int WeightW = 16;
	localparam int MagW    = ValueW + 1;
	localparam int SqW     = 2 * MagW - 1;
	localparam int TermW   = WeightW + SqW;
	localparam int SumW    = 52;
	localparam int CostW   = 26;
	localparam int RemW    = CostW + 1;

	// Square root iteration count (two radicand bits per step).
	localparam int RootSteps = SumW / 2;
	localparam int StepCntW  = $clog2(RootSteps);

	// Configuration port.
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam logic [CfgIdxW-1:0] RegNormMode = 3'd0;
	localparam logic [CfgIdxW-1:0] RegWeight0  = 3'd1;

	// Norm mode codes.
	localparam logic ModeL1 = 1'b0;
	localparam logic ModeL2 = 1'b1;

	// Reset weight: 1.0 in Q8.8.
	localparam logic [WeightW-1:0] WeightReset = 16'h0100;

	typedef logic [NumWeights-1:0][WeightW-1:0] weight_arr_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic square;
		logic multiply;
		logic accumulate;
		logic load_root;
		logic root_step;
		logic load_out;
	} wfd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pos_full;
	} wfd_status_t;

endpackage

[hdl/weighted_feature_distance_core.sv]
// ----------------------------------------------------------------------------
// Weighted feature distance core
// Streams feature pairs and reports the square root of their weighted distance.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction carries one feature pair (value_a, value_b, each
// signed Q12.4 with an undefined flag that makes it zero) and last_element.
// The block adds weight * |a - b| (L1 mode) or weight * (a - b)^2 (L2 mode)
// for positions 0 to 5; later positions add nothing and raise
// too_many_features. On the last element one output transaction delivers
// the floor square root of the sum, and the vector state clears.
// Sequence: an element passes through capture, square, weight multiply and
// accumulate, with in_stall high until it is done; the weight multiply uses
// the one multiplier shared by both modes. An element past position 5 is only
// captured. The last element then adds a load step, 26 square root steps (two
// radicand bits per step) and the output register load, which waits until
// the output slot is free.
// A finished result waits in the output register while in_stall is low for
// the next vector's elements; only a second result waits for the slot.
// Reset clears the sum, position and output valid, sets all weights to 1.0 and
// mode L1. The user must write configuration only while idle; not enforced.
// ----------------------------------------------------------------------------
module weighted_feature_distance_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [wfd_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [wfd_pkg::CfgDataW-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [wfd_pkg::ValueW-1:0] value_a,
	input  logic                              a_undefined,
	input  logic signed [wfd_pkg::ValueW-1:0] value_b,
	input  logic                              b_undefined,
	input  logic                              last_element,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [wfd_pkg::CostW-1:0]         cost,
	output logic                              too_many_features
);
	import wfd_pkg::*;

	logic        norm_mode;
	weight_arr_t weights;
	wfd_cmd_t    cmd;
	wfd_status_t status;

	wfd_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.norm_mode    (norm_mode),
		.weights      (weights)
	);

	wfd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.last_element (last_element),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.status       (status)
	);

	wfd_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.value_a           (value_a),
		.a_undefined       (a_undefined),
		.value_b           (value_b),
		.b_undefined       (b_undefined),
		.norm_mode         (norm_mode),
		.weights           (weights),
		.cost              (cost),
		.too_many_features (too_many_features)
	);

endmodule

[hdl/wfd_cfg.sv]
// ----------------------------------------------------------------------------
// Weighted feature distance configuration registers
// Holds the norm mode and the six position weights written over the write port.
// ----------------------------------------------------------------------------
module wfd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_en,
	input  logic [wfd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [wfd_pkg::CfgDataW-1:0] cfg_data,
	output logic                         norm_mode,
	output wfd_pkg::weight_arr_t         weights
);
	import wfd_pkg::*;

	logic        norm_mode_q;
	weight_arr_t weights_q;

	// Register writes; an index past the last weight is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_mode_q <= ModeL1;
			for (int i = 0; i < NumWeights; i++) begin
				weights_q[i] <= WeightReset;
			end
		end else if (cfg_write_en) begin
			if (cfg_index == RegNormMode) begin
				norm_mode_q <= cfg_data[0];
			end
			for (int i = 0; i < NumWeights; i++) begin
				if (cfg_index == CfgIdxW'(int'(RegWeight0) + i)) begin
					weights_q[i] <= cfg_data[WeightW-1:0];
				end
			end
		end
	end

	assign norm_mode = norm_mode_q;
	assign weights   = weights_q;

endmodule

[hdl/wfd_dp.sv]
// ----------------------------------------------------------------------------
// Weighted feature distance datapath
// Difference magnitude, shared multiplier, running sum and bit-pair square root.
// ----------------------------------------------------------------------------
module wfd_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wfd_pkg::wfd_cmd_t           cmd,
	output wfd_pkg::wfd_status_t        status,
	input  logic signed [wfd_pkg::ValueW-1:0] value_a,
	input  logic                        a_undefined,
	input  logic signed [wfd_pkg::ValueW-1:0] value_b,
	input  logic                        b_undefined,
	input  logic                        norm_mode,
	input  wfd_pkg::weight_arr_t        weights,
	output logic [wfd_pkg::CostW-1:0]   cost,
	output logic                        too_many_features
);
	import wfd_pkg::*;

	// Control state.
	logic [PosW-1:0]    pos_q;
	logic               ovf_q;
	logic [SumW-1:0]    sum_q;

	// Element payload registers.
	logic [MagW-1:0]    mag_q;
	logic               mode_q;
	logic [WeightW-1:0] weight_q;
	logic [SqW-1:0]     sq_q;
	logic [TermW-1:0]   term_q;

	// Square root registers.
	logic [SumW-1:0]    rad_q;
	logic [RemW-1:0]    rem_q;
	logic [CostW-1:0]   root_q;
	logic               flag_q;

	// Output registers.
	logic [CostW-1:0]   cost_q;
	logic               tmf_q;

	logic [MagW-1:0]    a_ext;
	logic [MagW-1:0]    b_ext;
	logic [MagW-1:0]    diff;
	logic [MagW-1:0]    mag;
	logic [WeightW-1:0] weight_sel;
	logic [SqW-1:0]     mul_b;
	logic [TermW-1:0]   product;
	logic [RemW+1:0]    rem_shift;
	logic [RemW+1:0]    trial;
	logic               take;

	assign status.pos_full = (pos_q >= PosW'(MaxFeatures));

	// Difference magnitude of the two values, undefined ones read as zero.
	always_comb begin
		a_ext = a_undefined ? '0 : {value_a[ValueW-1], value_a};
		b_ext = b_undefined ? '0 : {value_b[ValueW-1], value_b};
		diff  = a_ext - b_ext;
		mag   = diff[MagW-1] ? (~diff + MagW'(1)) : diff;
	end

	// Weight of the current position.
	always_comb begin
		weight_sel = '0;
		for (int i = 0; i < NumWeights; i++) begin
			if (pos_q == PosW'(i)) begin
				weight_sel = weights[i];
			end
		end
	end

	// Shared weight multiplier: magnitude in L1 mode, square in L2 mode.
	assign mul_b   = (mode_q == ModeL2) ? sq_q : SqW'(mag_q);
	assign product = TermW'(weight_q) * TermW'(mul_b);

	// One square root step: bring down two radicand bits and try to subtract.
	assign rem_shift = {rem_q, rad_q[SumW-1 -: 2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign take      = (rem_shift >= trial);

	// Element payload capture and multiplier pipeline.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mag_q    <= mag;
			mode_q   <= norm_mode;
			weight_q <= weight_sel;
		end
		if (cmd.square) begin
			sq_q <= SqW'(mag_q) * SqW'(mag_q);
		end
		if (cmd.multiply) begin
			term_q <= product;
		end
	end

	// Running sum, position and overflow mark for the current vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ovf_q <= 1'b0;
			sum_q <= '0;
		end else if (cmd.load_root) begin
			pos_q <= '0;
			ovf_q <= 1'b0;
			sum_q <= '0;
		end else begin
			if (cmd.capture) begin
				if (status.pos_full) begin
					ovf_q <= 1'b1;
				end else begin
					pos_q <= pos_q + PosW'(1);
				end
			end
			if (cmd.accumulate) begin
				sum_q <= sum_q + SumW'(term_q);
			end
		end
	end

	// Integer square root, one result bit per step.
	always_ff @(posedge clk) begin
		if (cmd.load_root) begin
			rad_q  <= sum_q;
			rem_q  <= '0;
			root_q <= '0;
			flag_q <= ovf_q;
		end else if (cmd.root_step) begin
			rad_q  <= {rad_q[SumW-3:0], 2'b00};
			rem_q  <= take ? RemW'(rem_shift - trial) : RemW'(rem_shift);
			root_q <= {root_q[CostW-2:0], take};
		end
	end

	// Result register toward the output channel.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cost_q <= root_q;
			tmf_q  <= flag_q;
		end
	end

	assign cost              = cost_q;
	assign too_many_features = tmf_q;

endmodule

[hdl/wfd_ctrl.sv]
// ----------------------------------------------------------------------------
// Weighted feature distance controller
// Sequences each element through the datapath and runs the square root.
// ----------------------------------------------------------------------------
module wfd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 last_element,
	output logic                 out_valid,
	input  logic                 out_stall,
	output wfd_pkg::wfd_cmd_t    cmd,
	input  wfd_pkg::wfd_status_t status
);
	import wfd_pkg::*;

	localparam logic [2:0] StIdle   = 3'd0;
	localparam logic [2:0] StSquare = 3'd1;
	localparam logic [2:0] StMul    = 3'd2;
	localparam logic [2:0] StAcc    = 3'd3;
	localparam logic [2:0] StLoad   = 3'd4;
	localparam logic [2:0] StRoot   = 3'd5;
	localparam logic [2:0] StOut    = 3'd6;

	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic                last_q;
	logic [StepCntW-1:0] step_q;
	logic                out_valid_q;
	logic                in_accept;
	logic                slot_free;

	assign in_stall  = (state_q != StIdle);
	assign in_accept = in_valid && (state_q == StIdle);
	assign slot_free = !out_valid_q || !out_stall;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			StIdle: begin
				if (in_accept) begin
					cmd.capture = 1'b1;
					if (!status.pos_full) begin
						state_d = StSquare;
					end else if (last_element) begin
						state_d = StLoad;
					end
				end
			end
			StSquare: begin
				cmd.square = 1'b1;
				state_d    = StMul;
			end
			StMul: begin
				cmd.multiply = 1'b1;
				state_d      = StAcc;
			end
			StAcc: begin
				cmd.accumulate = 1'b1;
				state_d        = last_q ? StLoad : StIdle;
			end
			StLoad: begin
				cmd.load_root = 1'b1;
				state_d       = StRoot;
			end
			StRoot: begin
				cmd.root_step = 1'b1;
				if (step_q == StepCntW'(RootSteps - 1)) begin
					state_d = StOut;
				end
			end
			StOut: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = StIdle;
				end
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	// State, last mark and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			last_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				last_q <= last_element;
			end
			if (cmd.load_root) begin
				step_q <= '0;
			end else if (cmd.root_step) begin
				step_q <= step_q + StepCntW'(1);
			end
		end
	end

	// Output valid: set when a result loads, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[tb/sv/wfd_distance_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted feature distance checker
// Watches the configuration port and both channels of the distance core. It
// keeps its own copy of the weights, the norm mode and the running vector
// state, predicts the cost and overflow flag of every finished vector, and
// compares each output transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module wfd_distance_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [wfd_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [wfd_pkg::CfgDataW-1:0]      cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic signed [wfd_pkg::ValueW-1:0] value_a,
	input  logic                              a_undefined,
	input  logic signed [wfd_pkg::ValueW-1:0] value_b,
	input  logic                              b_undefined,
	input  logic                              last_element,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [wfd_pkg::CostW-1:0]         cost,
	input  logic                              too_many_features,
	output int unsigned                       error_count,
	output int unsigned                       pending_count,
	output int unsigned                       results_seen
);
	import wfd_pkg::*;

	localparam int MaxReports = 10;

	typedef struct packed {
		logic [CostW-1:0] cost;
		logic             too_many;
	} distance_t;

	// Shadow configuration and vector state.
	logic             mode_q;
	logic [WeightW-1:0] weights_q [NumWeights];
	logic [SumW-1:0]  sum_q;
	logic [PosW-1:0]  pos_q;
	logic             overflow_q;

	distance_t expected_distances [$];

	// Weighted contribution of one feature pair, as wide as any term can be.
	function automatic logic [63:0] weighted_term(input logic l2, input logic [WeightW-1:0] w,
			input logic signed [ValueW-1:0] a, input logic a_undef,
			input logic signed [ValueW-1:0] b, input logic b_undef);
		logic signed [ValueW+1:0] av;
		logic signed [ValueW+1:0] bv;
		logic signed [ValueW+1:0] diff;
		logic [63:0]              mag;
		if (a_undef) av = '0;
		else av = a;
		if (b_undef) bv = '0;
		else bv = b;
		diff = av - bv;
		mag = diff[ValueW+1] ? 64'(-diff) : 64'(diff);
		return l2 ? 64'(w) * mag * mag : 64'(w) * mag;
	endfunction

	// Floor square root, built one result bit at a time from the top.
	function automatic logic [CostW-1:0] floor_root(input logic [SumW-1:0] radicand);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int i = CostW - 1; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= 64'(radicand))
				root = trial;
		end
		return root[CostW-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : distance_model
		distance_t        got;
		distance_t        want;
		logic [SumW-1:0]  sum_next;
		logic [PosW-1:0]  pos_next;
		logic             ovf_next;
		if (!arst_n) begin
			mode_q     <= ModeL1;
			sum_q      <= '0;
			pos_q      <= '0;
			overflow_q <= 1'b0;
			for (int i = 0; i < NumWeights; i++)
				weights_q[i] <= WeightReset;
			expected_distances.delete();
			pending_count <= 0;
			error_count  = 0;
			results_seen = 0;
		end else begin
			// Register writes only happen while the core is idle.
			if (cfg_write_en) begin
				if (cfg_index == RegNormMode)
					mode_q <= cfg_data[0];
				else if (cfg_index >= RegWeight0 && cfg_index < RegWeight0 + NumWeights)
					weights_q[cfg_index - RegWeight0] <= cfg_data[WeightW-1:0];
			end

			// Output transaction: compare with the oldest prediction.
			if (out_valid && !out_stall) begin
				got.cost     = cost;
				got.too_many = too_many_features;
				results_seen++;
				if (expected_distances.size() == 0) begin
					if (error_count < MaxReports)
						$display("[%0t] unexpected distance result: cost %0d too_many %0b",
							$realtime, got.cost, got.too_many);
					error_count++;
				end else begin
					want = expected_distances.pop_front();
					if (got.cost !== want.cost || got.too_many !== want.too_many) begin
						if (error_count < MaxReports)
							$display("[%0t] distance mismatch on result %0d: ",
								"expected cost %0d too_many %0b, ",
								"got cost %0d too_many %0b",
								$realtime, results_seen, want.cost, want.too_many,
								got.cost, got.too_many);
						error_count++;
					end
				end
			end

			// Input transaction: accumulate, and predict a result on the last element.
			if (in_valid && !in_stall) begin
				sum_next = sum_q;
				pos_next = pos_q;
				ovf_next = overflow_q;
				if (pos_q < MaxFeatures) begin
					sum_next = sum_q + SumW'(weighted_term(mode_q, weights_q[pos_q], value_a,
						a_undefined, value_b, b_undefined));
					pos_next = pos_q + PosW'(1);
				end else begin
					ovf_next = 1'b1;
				end
				if (last_element) begin
					want.cost     = floor_root(sum_next);
					want.too_many = ovf_next;
					expected_distances.push_back(want);
					sum_q      <= '0;
					pos_q      <= '0;
					overflow_q <= 1'b0;
				end else begin
					sum_q      <= sum_next;
					pos_q      <= pos_next;
					overflow_q <= ovf_next;
				end
			end

			pending_count <= expected_distances.size();
		end
	end

endmodule

[tb/sv/tb_weighted_feature_distance_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted feature distance core testbench
// Streams feature vectors through the core under several weight and norm
// settings, with random sender bursts and receiver stalls. A checker module
// beside the core predicts every result and counts mismatches; this module
// generates stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_weighted_feature_distance_core;
	import wfd_pkg::*;

	localparam int RandomItems   = 1350;
	localparam int RandomPhases  = 6;
	localparam int SettleCycles  = 48;
	localparam int WatchdogLimit = 4000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write_en = 1'b0;
	logic [CfgIdxW-1:0]       cfg_index = '0;
	logic [CfgDataW-1:0]      cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [ValueW-1:0] value_a = '0;
	logic                     a_undefined = 1'b0;
	logic signed [ValueW-1:0] value_b = '0;
	logic                     b_undefined = 1'b0;
	logic                     last_element = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [CostW-1:0]         cost;
	logic                     too_many_features;

	int unsigned error_count;
	int unsigned pending_count;
	int unsigned results_seen;

	int          burst_left = 0;
	int          items_sent = 0;
	int          vectors_sent = 0;
	int          long_vectors = 0;
	int          settings_used = 0;
	logic        mode_now = ModeL1;
	int          stall_phase_left = 0;
	int          stall_pct = 0;
	int          idle_cycles = 0;

	weighted_feature_distance_core u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.value_a           (value_a),
		.a_undefined       (a_undefined),
		.value_b           (value_b),
		.b_undefined       (b_undefined),
		.last_element      (last_element),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.cost              (cost),
		.too_many_features (too_many_features)
	);

	wfd_distance_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.value_a           (value_a),
		.a_undefined       (a_undefined),
		.value_b           (value_b),
		.b_undefined       (b_undefined),
		.last_element      (last_element),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.cost              (cost),
		.too_many_features (too_many_features),
		.error_count       (error_count),
		.pending_count     (pending_count),
		.results_seen      (results_seen)
	);

	always #6 clk = ~clk;

	// Receiver stalls in phases: none, light, heavy or nearly always.
	always @(posedge clk) begin
		if (stall_phase_left == 0) begin
			stall_phase_left <= $urandom_range(20, 200);
			case ($urandom_range(0, 3))
				0: stall_pct <= 0;
				1: stall_pct <= 25;
				2: stall_pct <= 60;
				default: stall_pct <= 90;
			endcase
		end else begin
			stall_phase_left <= stall_phase_left - 1;
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Watchdog: end the run if no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WatchdogLimit) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Feature value biased toward the extremes of Q12.4.
	function automatic logic signed [ValueW-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return ValueW'($urandom);
		endcase
	endfunction

	function automatic logic rand_undefined();
		return ($urandom_range(0, 9) == 0);
	endfunction

	// One input transaction, preceded by a random gap when a burst runs out.
	task automatic send_element(input logic signed [ValueW-1:0] a, input logic a_undef,
			input logic signed [ValueW-1:0] b, input logic b_undef, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid     <= 1'b1;
		value_a      <= a;
		a_undefined  <= a_undef;
		value_b      <= b;
		b_undefined  <= b_undef;
		last_element <= last;
		do @(posedge clk); while (in_stall);
		burst_left--;
		items_sent++;
		if (last)
			vectors_sent++;
	endtask

	// Drain all results and give the core time to finish any element in flight.
	task automatic wait_quiet();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= data;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_settings(input logic mode, input logic [WeightW-1:0] w [NumWeights]);
		write_reg(RegNormMode, CfgDataW'(mode));
		for (int i = 0; i < NumWeights; i++)
			write_reg(RegWeight0 + CfgIdxW'(i), w[i]);
		mode_now = mode;
		settings_used++;
	endtask

	// A vector of random pairs; a nonzero flip_at toggles the norm mode mid-vector.
	task automatic send_vector(input int len, input int flip_at);
		for (int i = 0; i < len; i++) begin
			if (flip_at != 0 && i == flip_at) begin
				wait_quiet();
				mode_now = ~mode_now;
				write_reg(RegNormMode, CfgDataW'(mode_now));
			end
			send_element(rand_value(), rand_undefined(), rand_value(), rand_undefined(),
				i == len - 1);
		end
		if (len > MaxFeatures)
			long_vectors++;
	endtask

	initial begin
		logic [WeightW-1:0] w [NumWeights];
		int directed_items;
		int len;
		int flip_at;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: L1, unit weights. Extremes and undefined values.
		send_element(16'sh7FFF, 1'b0, 16'sh8000, 1'b0, 1'b1);
		send_element(16'sh8000, 1'b0, 16'sh7FFF, 1'b1, 1'b1);
		send_element(16'sh1234, 1'b1, 16'sh8000, 1'b0, 1'b1);
		send_element(16'sh7FFF, 1'b1, 16'sh8000, 1'b1, 1'b1);
		send_element(16'shFFFF, 1'b0, 16'shFFFF, 1'b0, 1'b1);
		// A vector past six elements raises the overflow flag.
		send_vector(7, 0);

		// Largest weights in L2 mode: the biggest single term and the biggest sum.
		wait_quiet();
		w = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		write_settings(ModeL2, w);
		send_element(16'sh8000, 1'b0, 16'sh7FFF, 1'b0, 1'b1);
		for (int i = 0; i < MaxFeatures; i++)
			send_element(16'sh7FFF, 1'b0, 16'sh8000, 1'b0, i == MaxFeatures - 1);

		// Mixed weights including zero, with a norm mode change inside the vector.
		wait_quiet();
		w = '{16'h0000, 16'h0001, 16'h0100, 16'h1000, 16'h8000, 16'hFFFF};
		write_settings(ModeL2, w);
		send_vector(4, 2);
		directed_items = items_sent;

		// Random phases, each under fresh register settings.
		for (int phase = 0; phase < RandomPhases; phase++) begin
			wait_quiet();
			for (int i = 0; i < NumWeights; i++) begin
				case ($urandom_range(0, 9))
					0: w[i] = 16'h0000;
					1: w[i] = 16'hFFFF;
					2: w[i] = 16'h0100;
					default: w[i] = WeightW'($urandom);
				endcase
			end
			write_settings(logic'($urandom_range(0, 1)), w);
			flip_at = 0;
			while (items_sent - directed_items < (phase + 1) * RandomItems / RandomPhases) begin
				len = ($urandom_range(0, 6) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
				if (flip_at == 0 && len > 1 && $urandom_range(0, 1) == 1)
					flip_at = $urandom_range(1, len - 1);
				else
					flip_at = -1;
				send_vector(len, (flip_at > 0) ? flip_at : 0);
			end
		end

		// Drain and let any stray output show up before the verdict.
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (SettleCycles) @(posedge clk);

		$display("Sent %0d feature pairs in %0d vectors (%0d longer than six) under %0d settings.",
			items_sent, vectors_sent, long_vectors, settings_used);
		$display("Compared %0d distance results, %0d mismatches.", results_seen, error_count);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
